// ===== rtl/smi_pkg.sv =====
// Shared types, constants and helper functions for the simplex monomial integral block.
// It has no dependencies. smi_fpu and simplex_monomial_integral use it.
`timescale 1ns / 1ps
`default_nettype none
package smi_pkg;

  localparam int MAX_DIM = 8;
  localparam int EXP_W   = 5;
  localparam int DIM_W   = 4;
  localparam int FA_W    = 9;   // The running counter reaches at most 8*31+9.

  localparam logic [63:0] DBL_ONE  = 64'h3FF0000000000000;
  localparam logic [63:0] DBL_ZERO = 64'h0000000000000000;

  typedef enum logic {
    FPU_MUL = 1'b0,
    FPU_DIV = 1'b1
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  // These are correctly rounded doubles of sqrt(d) for d = 0..8.
  function automatic logic [63:0] sqrt_tab(input logic [DIM_W-1:0] d);
    logic [63:0] v;
    begin
      case (d)
        4'd0:    v = 64'h0000000000000000;
        4'd1:    v = 64'h3FF0000000000000;
        4'd2:    v = 64'h3FF6A09E667F3BCD;
        4'd3:    v = 64'h3FFBB67AE8584CAA;
        4'd4:    v = 64'h4000000000000000;
        4'd5:    v = 64'h4001E3779B97F4A8;
        4'd6:    v = 64'h4003988E1409212E;
        4'd7:    v = 64'h40052A7FA9D2F8EA;
        4'd8:    v = 64'h4006A09E667F3BCD;
        default: v = 64'h0000000000000000;
      endcase
      return v;
    end
  endfunction

  // This converts a nonzero small integer into an exact double.
  function automatic logic [63:0] int_to_double(input logic [FA_W-1:0] v);
    logic [3:0]  msb;
    logic [52:0] m;
    begin
      msb = 4'd0;
      for (int i = 0; i < FA_W; i++) begin
        if (v[i]) msb = 4'(i);
      end
      m = 53'(v) << (6'd52 - 6'(msb));
      return {1'b0, 11'(11'd1023 + 11'(msb)), m[51:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/smi_fpu.sv =====
// Iterative double multiply and divide unit for positive normal operands, rounded to nearest even.
// It depends on smi_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none
module smi_fpu (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire smi_pkg::fpu_req_t req,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     b,
  output logic                 done,
  output logic [63:0]          result
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_RND} fstate_t;

  fstate_t              state_r;
  smi_pkg::fpu_op_t     op_r;
  logic [52:0]          ma_r, mb_r;
  logic [108:0]         p_r;
  logic [54:0]          q_r;
  logic [53:0]          rem_r;
  logic signed [12:0]   exp_r;
  logic [5:0]           cnt_r;
  logic                 done_r;
  logic [63:0]          result_r;

  logic [56:0]          upper;
  logic                 ge;
  logic [53:0]          diff;
  logic [52:0]          m;
  logic                 g, s, inc;
  logic signed [12:0]   e;
  logic [53:0]          mr;
  logic [63:0]          rounded;

  always_comb begin
    upper = 57'(p_r[108:56]) + 57'(ma_r) * 57'(p_r[3:0]);
    ge    = rem_r >= {1'b0, mb_r};
    diff  = rem_r - (ge ? {1'b0, mb_r} : 54'd0);
  end

  always_comb begin
    if (op_r == smi_pkg::FPU_MUL) begin
      if (p_r[105]) begin
        m = p_r[105:53]; g = p_r[52]; s = |p_r[51:0]; e = exp_r + 13'sd1;
      end else begin
        m = p_r[104:52]; g = p_r[51]; s = |p_r[50:0]; e = exp_r;
      end
    end else begin
      if (q_r[54]) begin
        m = q_r[54:2]; g = q_r[1]; s = q_r[0] | (|rem_r); e = exp_r;
      end else begin
        m = q_r[53:1]; g = q_r[0]; s = |rem_r; e = exp_r - 13'sd1;
      end
    end
    inc = g & (s | m[0]);
    mr  = 54'(m) + 54'(inc);
    if (mr[53]) begin
      rounded = {1'b0, 11'(e + 13'sd1), 52'd0};
    end else begin
      rounded = {1'b0, e[10:0], mr[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    case (state_r)
      F_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          ma_r  <= {1'b1, a[51:0]};
          mb_r  <= {1'b1, b[51:0]};
          p_r   <= {56'd0, 1'b1, b[51:0]};
          rem_r <= {2'b01, a[51:0]};
          q_r   <= '0;
          if (req.op == smi_pkg::FPU_MUL) begin
            exp_r   <= $signed(13'(a[62:52])) + $signed(13'(b[62:52])) - 13'sd1023;
            cnt_r   <= 6'd13;
            state_r <= F_MUL;
          end else begin
            exp_r   <= $signed(13'(a[62:52])) - $signed(13'(b[62:52])) + 13'sd1023;
            cnt_r   <= 6'd54;
            state_r <= F_DIV;
          end
        end
      end
      F_MUL: begin
        p_r   <= {upper, p_r[55:4]};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_r <= F_RND;
      end
      F_DIV: begin
        rem_r <= {diff[52:0], 1'b0};
        q_r   <= {q_r[53:0], ge};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_r <= F_RND;
      end
      F_RND: begin
        result_r <= rounded;
        done_r   <= 1'b1;
        state_r  <= F_IDLE;
      end
      default: state_r <= F_IDLE;
    endcase
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule
`default_nettype wire

// ===== rtl/simplex_monomial_integral.sv =====
// Top level: exact monomial integral over the reference simplex, as an IEEE double.
// It depends on smi_pkg and instantiates smi_fpu.
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | in_op, in_face, in_exp0 .. in_exp7
// out      | out_valid / out_ready| out_integral_bits
// cfg      | cfg_wen              | cfg_dimension
//
// Each request runs on one shared iterative multiply/divide unit. A request costs a
// division and a multiplication per unit of exponent sum plus one division per
// final divisor, plus the sequencer states between them. The worst case has all
// eight exponents at 31. Reset is synchronous and active low; it restores the
// dimension to 2 and idles the sequencer. in_ready stays low from acceptance
// until the result is taken, so a stalled output holds the block.
module simplex_monomial_integral (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [3:0]  cfg_dimension,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [3:0]  in_face,
  input  wire logic [4:0]  in_exp0,
  input  wire logic [4:0]  in_exp1,
  input  wire logic [4:0]  in_exp2,
  input  wire logic [4:0]  in_exp3,
  input  wire logic [4:0]  in_exp4,
  input  wire logic [4:0]  in_exp5,
  input  wire logic [4:0]  in_exp6,
  input  wire logic [4:0]  in_exp7,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_integral_bits
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_QWAIT, S_MWAIT, S_DIVS, S_DWAIT, S_OUT} state_t;

  state_t        state_r;
  logic [3:0]    dim_r;
  logic [4:0]    exp_r [8];
  logic [3:0]    d_r;
  logic [3:0]    idx_r;
  logic [5:0]    k_r;
  logic [8:0]    fa_r;
  logic [3:0]    ndiv_r;
  logic [63:0]   res_r;
  logic          out_valid_r;
  logic [63:0]   out_bits_r;

  logic [3:0]    d_eff;
  logic [4:0]    face_exp;
  logic          face_zero;
  logic [4:0]    cur_exp;

  smi_pkg::fpu_req_t fpu_req;
  logic [63:0]   fpu_a, fpu_b;
  logic          fpu_done;
  logic [63:0]   fpu_result;

  // A dimension above the supported maximum saturates.
  assign d_eff = (dim_r > 4'(smi_pkg::MAX_DIM)) ? 4'(smi_pkg::MAX_DIM) : dim_r;

  always_comb begin
    case (in_face)
      4'd1:    face_exp = in_exp0;
      4'd2:    face_exp = in_exp1;
      4'd3:    face_exp = in_exp2;
      4'd4:    face_exp = in_exp3;
      4'd5:    face_exp = in_exp4;
      4'd6:    face_exp = in_exp5;
      4'd7:    face_exp = in_exp6;
      4'd8:    face_exp = in_exp7;
      default: face_exp = 5'd0;
    endcase
    // A face beyond the dimension, or a flat face whose coordinate carries a
    // nonzero exponent, integrates to zero without any arithmetic.
    face_zero = in_op && ((in_face > d_eff) || (in_face != 4'd0 && face_exp != 5'd0));
    cur_exp   = exp_r[idx_r[2:0]];
  end

  // The sequencer issues the quotient k/fa, then the product with the running
  // result, for every unit of each exponent, then the final divisions.
  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = smi_pkg::FPU_DIV;
    fpu_a         = smi_pkg::int_to_double(9'(k_r));
    fpu_b         = smi_pkg::int_to_double(fa_r);
    case (state_r)
      S_SCAN: begin
        fpu_req.start = (idx_r != d_r) && (k_r <= 6'(cur_exp));
      end
      S_QWAIT: begin
        fpu_req.start = fpu_done;
        fpu_req.op    = smi_pkg::FPU_MUL;
        fpu_a         = res_r;
        fpu_b         = fpu_result;
      end
      S_DIVS: begin
        fpu_req.start = (ndiv_r != 4'd0);
        fpu_a         = res_r;
      end
      default: ;
    endcase
  end

  smi_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fpu_req),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_result)
  );

  always_ff @(posedge clk) begin
    if (cfg_wen) dim_r <= cfg_dimension;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          exp_r[0] <= in_exp0; exp_r[1] <= in_exp1;
          exp_r[2] <= in_exp2; exp_r[3] <= in_exp3;
          exp_r[4] <= in_exp4; exp_r[5] <= in_exp5;
          exp_r[6] <= in_exp6; exp_r[7] <= in_exp7;
          d_r   <= d_eff;
          idx_r <= 4'd0;
          k_r   <= 6'd1;
          fa_r  <= 9'd1;
          ndiv_r <= in_op ? ((d_eff != 4'd0) ? d_eff - 4'd1 : 4'd0) : d_eff;
          res_r <= (in_op && in_face == 4'd0) ? smi_pkg::sqrt_tab(d_eff) : smi_pkg::DBL_ONE;
          if (face_zero) begin
            out_bits_r  <= smi_pkg::DBL_ZERO;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == d_r) begin
          state_r <= S_DIVS;
        end else if (k_r > 6'(cur_exp)) begin
          idx_r <= idx_r + 4'd1;
          k_r   <= 6'd1;
        end else begin
          state_r <= S_QWAIT;
        end
      end
      S_QWAIT: begin
        if (fpu_done) state_r <= S_MWAIT;
      end
      S_MWAIT: begin
        if (fpu_done) begin
          res_r   <= fpu_result;
          k_r     <= k_r + 6'd1;
          fa_r    <= fa_r + 9'd1;
          state_r <= S_SCAN;
        end
      end
      S_DIVS: begin
        if (ndiv_r == 4'd0) begin
          out_bits_r  <= res_r;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end else begin
          state_r <= S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (fpu_done) begin
          res_r   <= fpu_result;
          fa_r    <= fa_r + 9'd1;
          ndiv_r  <= ndiv_r - 4'd1;
          state_r <= S_DIVS;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      end
      default: state_r <= S_IDLE;
    endcase
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= 4'd2;
      out_valid_r <= 1'b0;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_integral_bits = out_bits_r;

endmodule
`default_nettype wire

// ===== dv/simplex_monomial_integral_tb.sv =====
// Self-checking testbench for simplex_monomial_integral: directed and random monomials,
// checked against an in-bench real-arithmetic predictor over several dimension settings.
// It depends on the RTL of simplex_monomial_integral only (and smi_pkg through it).
`timescale 1ns / 1ps

module simplex_monomial_integral_tb;

  // A bound on how long no request may move on either channel. It must cover the
  // slowest request's arithmetic plus the longest output stall.
  localparam int STALL_LIMIT = 100000;

  // One monomial request as it is put on the input channel.
  typedef struct {
    logic       op;
    logic [3:0] face;
    logic [4:0] exps [8];
  } monomial_t;

  // Correctly rounded sqrt(d) for the slanted face, d = 0..8.
  localparam logic [63:0] SQRT_BITS [9] = '{
    64'h0000000000000000, 64'h3FF0000000000000, 64'h3FF6A09E667F3BCD,
    64'h3FFBB67AE8584CAA, 64'h4000000000000000, 64'h4001E3779B97F4A8,
    64'h4003988E1409212E, 64'h40052A7FA9D2F8EA, 64'h4006A09E667F3BCD
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [3:0]  cfg_dimension;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [3:0]  in_face;
  logic [4:0]  in_exp [8];
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_integral_bits;

  // The bench's own copy of the dimension register.
  logic [3:0]  dim_shadow;
  logic [63:0] expected_integrals [$];
  int          mismatch_count;
  int          requests_sent;
  int          results_checked;
  int          idle_cycles;
  bit          stimulus_done;

  simplex_monomial_integral uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wen          (cfg_wen),
    .cfg_dimension    (cfg_dimension),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_face          (in_face),
    .in_exp0          (in_exp[0]),
    .in_exp1          (in_exp[1]),
    .in_exp2          (in_exp[2]),
    .in_exp3          (in_exp[3]),
    .in_exp4          (in_exp[4]),
    .in_exp5          (in_exp[5]),
    .in_exp6          (in_exp[6]),
    .in_exp7          (in_exp[7]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_integral_bits(out_integral_bits)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Computes the integral, prod(e_i!)/(sum e_i + d)! for a volume, in the block's
  // order: each factor k/fa is a rounded double quotient, then trailing divisions by fa.
  function automatic logic [63:0] monomial_integral(input monomial_t m,
                                                    input logic [3:0] dim_reg);
    int  d;
    int  fa;
    int  ndiv;
    real acc;
    begin
      d = (dim_reg > 4'd8) ? 8 : int'(dim_reg);
      if (m.op) begin
        // A face number above d does not exist, and a coordinate face vanishes
        // when its own exponent is nonzero.
        if (int'(m.face) > d) return 64'h0;
        if (m.face != 4'd0 && m.exps[m.face - 1] != 5'd0) return 64'h0;
        acc = (m.face == 4'd0) ? $bitstoreal(SQRT_BITS[d]) : 1.0;
        ndiv = (d > 0) ? d - 1 : 0;
      end else begin
        acc = 1.0;
        ndiv = d;
      end
      fa = 1;
      for (int i = 0; i < d; i++) begin
        for (int k = 1; k <= int'(m.exps[i]); k++) begin
          acc = acc * (real'(k) / real'(fa));
          fa++;
        end
      end
      for (int k = 0; k < ndiv; k++) begin
        acc = acc / real'(fa);
        fa++;
      end
      return $realtobits(acc);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    begin
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(3, 40);
    end
  endfunction

  task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
    begin
      $display("MISMATCH at %0t: integral_bits got %h expected %h", $realtime, got, want);
      mismatch_count++;
    end
  endtask

  // Sends one request; the expectation is formed at the edge that accepts it.
  // The previous request's valid drops at a falling edge of its own, so the
  // next one is never raised at that same edge.
  task automatic send_monomial(input monomial_t m);
    int gap;
    begin
      gap = pick_gap();
      repeat (gap + 1) @(negedge clk);
      in_valid <= 1'b1;
      in_op    <= m.op;
      in_face  <= m.face;
      for (int i = 0; i < 8; i++) in_exp[i] <= m.exps[i];
      do @(posedge clk); while (!in_ready);
      expected_integrals.push_back(monomial_integral(m, dim_shadow));
      requests_sent++;
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Waits for every outstanding result, then writes the dimension register.
  task automatic set_dimension(input logic [3:0] value);
    begin
      wait (expected_integrals.size() == 0);
      @(negedge clk);
      cfg_wen       <= 1'b1;
      cfg_dimension <= value;
      @(negedge clk);
      cfg_wen    <= 1'b0;
      dim_shadow = value;
    end
  endtask

  function automatic monomial_t make_monomial(input logic op, input logic [3:0] face,
                                               input int max_exp);
    monomial_t m;
    begin
      m.op   = op;
      m.face = face;
      for (int i = 0; i < 8; i++) m.exps[i] = 5'($urandom_range(0, max_exp));
      return m;
    end
  endfunction

  // The reset value of the dimension, with zero and full exponents.
  task automatic test_reset_dimension();
    monomial_t m;
    begin
      m = make_monomial(1'b0, 4'd0, 0);
      send_monomial(m);
      for (int i = 0; i < 8; i++) m.exps[i] = 5'd31;
      send_monomial(m);
      m.op = 1'b1;
      send_monomial(m);
    end
  endtask

  // Dimension zero, one, full and beyond full, in both modes.
  task automatic test_dimension_extremes();
    monomial_t m;
    logic [3:0] dims [4] = '{4'd0, 4'd1, 4'd8, 4'd15};
    begin
      foreach (dims[j]) begin
        set_dimension(dims[j]);
        m = make_monomial(1'b0, 4'd0, 3);
        send_monomial(m);
        m.op = 1'b1;
        send_monomial(m);
      end
      // All eight exponents at their largest, the slowest request there is.
      set_dimension(4'd8);
      for (int i = 0; i < 8; i++) m.exps[i] = 5'd31;
      m.op = 1'b0;
      send_monomial(m);
    end
  endtask

  // Every face of a 3-simplex with its own exponent zero, face 2 also with it
  // nonzero, and face numbers past the dimension.
  task automatic test_faces();
    monomial_t m;
    begin
      set_dimension(4'd3);
      for (int f = 0; f <= 5; f++) begin
        m = make_monomial(1'b1, 4'(f), 4);
        if (f >= 1 && f <= 3) m.exps[f - 1] = 5'd0;
        send_monomial(m);
      end
      m = make_monomial(1'b1, 4'd2, 4);
      m.exps[1] = 5'd1;
      send_monomial(m);
      m.face = 4'd15;
      send_monomial(m);
    end
  endtask

  // Random requests over several dimensions; exponents are mostly small to keep
  // the run short, with an occasional full-range one.
  task automatic test_random_monomials();
    monomial_t m;
    int        max_exp;
    begin
      for (int n = 0; n < 100; n++) begin
        if (n % 20 == 0) set_dimension(4'($urandom_range(0, 15)));
        max_exp = ($urandom_range(0, 9) == 0) ? 31 : 7;
        m = make_monomial(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), max_exp);
        // Zeroing the face's own exponent now and then reaches the nonzero faces.
        if (m.op && m.face != 4'd0 && m.face <= 4'd8 && $urandom_range(0, 1))
          m.exps[m.face - 1] = 5'd0;
        send_monomial(m);
      end
    end
  endtask

  // Output side: random stalls of the result channel, with quiet stretches.
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        out_ready <= 1'b0;
        repeat (gap + 1) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_integrals.size() == 0) begin
        $display("UNEXPECTED result at %0t: %h", $realtime, out_integral_bits);
        mismatch_count++;
      end else begin
        if (out_integral_bits !== expected_integrals[0])
          report_mismatch(out_integral_bits, expected_integrals[0]);
        void'(expected_integrals.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!stimulus_done || expected_integrals.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_wen         = 1'b0;
    cfg_dimension   = 4'd0;
    in_valid        = 1'b0;
    in_op           = 1'b0;
    in_face         = 4'd0;
    for (int i = 0; i < 8; i++) in_exp[i] = 5'd0;
    dim_shadow      = 4'd2;
    mismatch_count  = 0;
    requests_sent   = 0;
    results_checked = 0;
    idle_cycles     = 0;
    stimulus_done   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_dimension();
    test_dimension_extremes();
    test_faces();
    test_random_monomials();

    stimulus_done = 1'b1;
    wait (expected_integrals.size() == 0);
    repeat (50) @(negedge clk);
    $display("Covered %0d monomial requests, %0d results checked, over dimensions 0..15",
             requests_sent, results_checked);
    $display("in volume and face mode, including vanishing and nonexistent faces.");
    if (mismatch_count == 0 && expected_integrals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
